// ===== hw/rtl/bcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmr_pkg
// shared types, register indexes and fixed constants of the motor regulator
// ----------------------------------------------------------------------------
package bcmr_pkg;

    localparam int FRAME_TICKS      = 12;
    localparam int SPEED_RATE_LIMIT = 200;
    localparam int SPEED_INT_LIMIT  = 500;
    localparam int CURVE_TARGET     = 60;
    localparam int STEER_LIMIT      = 60;
    localparam int CUT_HIGH         = -64;
    localparam int CUT_LOW          = -3328;
    localparam int GYRO_SCALE       = 4000;
    localparam int SPEED_STEPS      = 3;
    localparam int STEER_STEPS      = 4;
    localparam int RECIP3_SHIFT     = 20;
    localparam logic [18:0] RECIP3  = 19'd349526;
    localparam int RECIP_SHIFT      = 16;

    typedef enum logic [3:0] {
        CFG_TILT_SETPOINT = 4'd0,
        CFG_ANGLE_KP      = 4'd1,
        CFG_ANGLE_KD      = 4'd2,
        CFG_SPEED_KP      = 4'd3,
        CFG_SPEED_KI      = 4'd4,
        CFG_SPEED_TARGET  = 4'd5,
        CFG_DIRECTION_KP  = 4'd6,
        CFG_DIRECTION_KD  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [14:0] tilt_setpoint;
        logic signed [23:0] angle_kp;
        logic signed [23:0] angle_kd;
        logic signed [23:0] speed_kp;
        logic signed [23:0] speed_ki;
        logic signed [10:0] speed_target;
        logic signed [23:0] direction_kp;
        logic signed [23:0] direction_kd;
    } t_cfg;

    typedef struct packed {
        logic signed [14:0] tilt_angle;
        logic signed [15:0] pitch_rate_raw;
        logic signed [15:0] yaw_rate_raw;
        logic signed [11:0] left_count;
        logic signed [11:0] right_count;
        logic        [7:0]  line_center;
        logic               curve_flag;
    } t_in_item;

    typedef struct packed {
        logic [9:0] right_forward_duty;
        logic [9:0] right_reverse_duty;
        logic [9:0] left_forward_duty;
        logic [9:0] left_reverse_duty;
        logic       motors_cut;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_PD,
        ST_DRIVE,
        ST_STR_MUL_A,
        ST_STR_MUL_B,
        ST_STR_SUM,
        ST_STR_NORM,
        ST_STR_DIV,
        ST_SPD_FILT,
        ST_SPD_INT,
        ST_SPD_MUL,
        ST_SPD_SUM,
        ST_SPD_OUT,
        ST_DONE
    } t_step;

    typedef struct packed {
        t_step step;
        logic  load;
        logic  publish;
    } t_dp_cmd;

    typedef struct packed {
        logic steer_due;
        logic speed_due;
    } t_dp_stat;

    // bit k set when tick k of the frame is a multiple of the period
    function automatic logic [15:0] f_period_mask(input int period);
        logic [15:0] m;
        int          cnt;
        m   = '0;
        cnt = 0;
        for (int i = 1; i <= FRAME_TICKS; i++) begin
            cnt = cnt + 1;
            if (cnt == period) begin
                m[i] = 1'b1;
                cnt  = 0;
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/bcmr_if.sv =====
// ----------------------------------------------------------------------------
// bcmr interfaces
// valid/ready channels for sensor beats, duty beats and register writes
// ----------------------------------------------------------------------------
interface bcmr_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] tilt_angle;
    logic signed [15:0] pitch_rate_raw;
    logic signed [15:0] yaw_rate_raw;
    logic signed [11:0] left_count;
    logic signed [11:0] right_count;
    logic        [7:0]  line_center;
    logic               curve_flag;

    modport source (output valid, tilt_angle, pitch_rate_raw, yaw_rate_raw, left_count,
                    right_count, line_center, curve_flag, input ready);
    modport sink   (input valid, tilt_angle, pitch_rate_raw, yaw_rate_raw, left_count,
                    right_count, line_center, curve_flag, output ready);
endinterface

interface bcmr_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] right_forward_duty;
    logic [9:0] right_reverse_duty;
    logic [9:0] left_forward_duty;
    logic [9:0] left_reverse_duty;
    logic       motors_cut;

    modport source (output valid, right_forward_duty, right_reverse_duty,
                    left_forward_duty, left_reverse_duty, motors_cut, input ready);
    modport sink   (input valid, right_forward_duty, right_reverse_duty,
                    left_forward_duty, left_reverse_duty, motors_cut, output ready);
endinterface

interface bcmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/balance_car_motor_regulator_unit.sv =====
// ----------------------------------------------------------------------------
// balance_car_motor_regulator_unit
// cascaded balance, speed and steering regulator for a two-wheel robot
// ----------------------------------------------------------------------------
// One input beat is one control tick and gives one duty beat. The result is
// valid once the sequencer has stepped through the registered multiplier
// stages of the balance term and, on steering ticks or speed ticks, of those
// loops as well; the next beat is taken in the cycle after the result is
// published, and a finished tick waits while the previous result still sits
// unaccepted in the output register.
// Register writes are always ready; indexes past the list are ignored.
module balance_car_motor_regulator_unit import bcmr_pkg::*; #(
    parameter int PWM_MAX      = 700,
    parameter int SPEED_PERIOD = 6,
    parameter int STEER_PERIOD = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcmr_in_if.sink     i_in,
    bcmr_out_if.source  o_out,
    bcmr_cfg_if.sink    i_cfg
);

    t_cfg      r_cfg;
    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_in_item  w_item;
    t_out_item w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_setpoint <= -15'sd1907;
            r_cfg.angle_kp      <= 24'sd212992;
            r_cfg.angle_kd      <= -24'sd139264;
            r_cfg.speed_kp      <= 24'sd13107;
            r_cfg.speed_ki      <= 24'sd16;
            r_cfg.speed_target  <= 11'sd120;
            r_cfg.direction_kp  <= 24'sd65536;
            r_cfg.direction_kd  <= -24'sd4915;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TILT_SETPOINT: r_cfg.tilt_setpoint <= i_cfg.data[14:0];
                CFG_ANGLE_KP:      r_cfg.angle_kp      <= i_cfg.data;
                CFG_ANGLE_KD:      r_cfg.angle_kd      <= i_cfg.data;
                CFG_SPEED_KP:      r_cfg.speed_kp      <= i_cfg.data;
                CFG_SPEED_KI:      r_cfg.speed_ki      <= i_cfg.data;
                CFG_SPEED_TARGET:  r_cfg.speed_target  <= i_cfg.data[10:0];
                CFG_DIRECTION_KP:  r_cfg.direction_kp  <= i_cfg.data;
                CFG_DIRECTION_KD:  r_cfg.direction_kd  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_item.tilt_angle     = i_in.tilt_angle;
    assign w_item.pitch_rate_raw = i_in.pitch_rate_raw;
    assign w_item.yaw_rate_raw   = i_in.yaw_rate_raw;
    assign w_item.left_count     = i_in.left_count;
    assign w_item.right_count    = i_in.right_count;
    assign w_item.line_center    = i_in.line_center;
    assign w_item.curve_flag     = i_in.curve_flag;

    bcmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bcmr_dp #(
        .PWM_MAX      (PWM_MAX),
        .SPEED_PERIOD (SPEED_PERIOD),
        .STEER_PERIOD (STEER_PERIOD)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (r_cfg),
        .i_item  (w_item),
        .o_res   (w_res)
    );

    assign o_out.right_forward_duty = w_res.right_forward_duty;
    assign o_out.right_reverse_duty = w_res.right_reverse_duty;
    assign o_out.left_forward_duty  = w_res.left_forward_duty;
    assign o_out.left_reverse_duty  = w_res.left_reverse_duty;
    assign o_out.motors_cut         = w_res.motors_cut;

    a_cut_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.motors_cut |->
            o_out.right_forward_duty == 0 && o_out.right_reverse_duty == 0 &&
            o_out.left_forward_duty == 0 && o_out.left_reverse_duty == 0)
        else $error("drive not zero while cut");

    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            !(o_out.right_forward_duty != 0 && o_out.right_reverse_duty != 0) &&
            !(o_out.left_forward_duty != 0 && o_out.left_reverse_duty != 0))
        else $error("wheel driven both ways");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            o_out.right_forward_duty <= 10'(PWM_MAX) &&
            o_out.right_reverse_duty <= 10'(PWM_MAX) &&
            o_out.left_forward_duty <= 10'(PWM_MAX) &&
            o_out.left_reverse_duty <= 10'(PWM_MAX))
        else $error("duty above limit");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("beat taken while tick in progress");

endmodule

// ===== hw/rtl/bcmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcmr_ctrl
// sequencer for one tick: balance term, optional steering and speed loops
// ----------------------------------------------------------------------------
module bcmr_ctrl import bcmr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_step r_state, n_state;
    logic  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.step    = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.publish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SUM;
            ST_SUM:   n_state = ST_PD;
            ST_PD:    n_state = ST_DRIVE;
            ST_DRIVE: begin
                priority if (i_stat.steer_due) n_state = ST_STR_MUL_A;
                else if (i_stat.speed_due)     n_state = ST_SPD_FILT;
                else                           n_state = ST_DONE;
            end
            ST_STR_MUL_A: n_state = ST_STR_MUL_B;
            ST_STR_MUL_B: n_state = ST_STR_SUM;
            ST_STR_SUM:   n_state = ST_STR_NORM;
            ST_STR_NORM:  n_state = ST_STR_DIV;
            ST_STR_DIV:   n_state = i_stat.speed_due ? ST_SPD_FILT : ST_DONE;
            ST_SPD_FILT:  n_state = ST_SPD_INT;
            ST_SPD_INT:   n_state = ST_SPD_MUL;
            ST_SPD_MUL:   n_state = ST_SPD_SUM;
            ST_SPD_SUM:   n_state = ST_SPD_OUT;
            ST_SPD_OUT:   n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish)    n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/bcmr_dp.sv =====
// ----------------------------------------------------------------------------
// bcmr_dp
// arithmetic and loop state of the regulator, one step per command
// ----------------------------------------------------------------------------
module bcmr_dp import bcmr_pkg::*; #(
    parameter int PWM_MAX      = 700,
    parameter int SPEED_PERIOD = 6,
    parameter int STEER_PERIOD = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_res
);

    localparam logic [15:0] STEER_MASK  = f_period_mask(STEER_PERIOD);
    localparam logic [15:0] SPEED_MASK  = f_period_mask(SPEED_PERIOD);
    localparam int          DIV_LIM     = STEER_LIMIT * STEER_PERIOD;
    localparam logic [16:0] STEER_RECIP = 17'((65536 + STEER_PERIOD - 1) / STEER_PERIOD);

    // latched item
    logic signed [14:0] r_tilt;
    logic signed [15:0] r_pitch;
    logic signed [11:0] r_lc, r_rc;
    logic        [7:0]  r_line;
    logic               r_curve;

    // loop state
    logic        [3:0]  r_phase;
    logic signed [19:0] r_yaw_sum;
    logic signed [12:0] r_fspeed;
    logic signed [9:0]  r_int;
    logic signed [15:0] r_scmd;
    logic signed [7:0]  r_stcmd;
    logic signed [15:0] r_ss;
    logic        [1:0]  r_sstep;
    logic signed [7:0]  r_st;
    logic        [2:0]  r_tstep;

    // work registers
    logic signed [39:0] r_pa, r_pb;
    logic signed [52:0] r_pb4k;
    logic signed [53:0] r_num;
    logic signed [25:0] r_pd;
    logic signed [19:0] r_sprod;
    logic signed [11:0] r_tprod;
    logic        [37:0] r_smag;
    logic               r_sneg;
    logic signed [33:0] r_t1;
    logic signed [43:0] r_t2;
    logic signed [57:0] r_t1s, r_t2s, r_snum;
    logic        [9:0]  r_qa;
    logic               r_qsat, r_qneg;
    logic signed [13:0] r_serr;
    logic signed [37:0] r_m1;
    logic signed [33:0] r_m2;
    logic signed [38:0] r_s;
    t_out_item          r_res, r_out;

    logic signed [15:0] w_terr;
    logic signed [16:0] w_sd;
    logic signed [8:0]  w_td;
    logic signed [19:0] w_sabs;
    logic signed [53:0] w_num_adj;
    logic        [16:0] w_sq;
    logic signed [11:0] w_tabs;
    logic signed [7:0]  w_tq;
    logic signed [27:0] w_right, w_left, w_rcl, w_lcl;
    logic               w_cut;
    logic signed [9:0]  w_lo;
    logic signed [57:0] w_smag;
    logic        [29:0] w_a;
    logic        [26:0] w_qprod;
    logic        [6:0]  w_q;
    logic signed [12:0] w_msum, w_mid;
    logic signed [13:0] w_fd, w_isum;
    logic signed [12:0] w_target;
    logic signed [38:0] w_s_adj;
    logic signed [26:0] w_sdiv;

    always_comb begin
        w_terr    = 16'(r_tilt) - 16'(i_cfg.tilt_setpoint);
        w_sd      = 17'(r_scmd) - 17'(r_ss);
        w_td      = 9'(r_stcmd) - 9'(r_st);
        w_sabs    = r_sprod[19] ? -r_sprod : r_sprod;
        w_num_adj = r_num[53] ? r_num + 54'sd268435455 : r_num;
        w_sq      = 17'(r_smag >> RECIP3_SHIFT);
        w_tabs    = r_tprod[11] ? -r_tprod : r_tprod;
        w_tq      = 8'(w_tabs >>> 2);
        w_right   = 28'(r_pd) - 28'(r_ss) + 28'(r_st);
        w_left    = 28'(r_pd) - 28'(r_ss) - 28'(r_st);
        w_cut     = (r_tilt >= 15'(CUT_HIGH)) || (r_tilt <= 15'(CUT_LOW));
        if (w_cut) begin
            w_right = '0;
            w_left  = '0;
        end
        w_rcl = w_right;
        if (w_right > 28'(PWM_MAX))       w_rcl = 28'(PWM_MAX);
        else if (w_right < -28'(PWM_MAX)) w_rcl = -28'(PWM_MAX);
        w_lcl = w_left;
        if (w_left > 28'(PWM_MAX))        w_lcl = 28'(PWM_MAX);
        else if (w_left < -28'(PWM_MAX))  w_lcl = -28'(PWM_MAX);
        w_lo     = $signed({1'b0, r_line, 1'b0}) - 10'sd79;
        w_smag   = r_snum[57] ? -r_snum : r_snum;
        w_a      = 30'(w_smag >>> 28);
        w_qprod  = 27'(r_qa) * 27'(STEER_RECIP);
        w_q      = r_qsat ? 7'(STEER_LIMIT) : 7'(w_qprod >> RECIP_SHIFT);
        w_msum   = 13'(r_lc) + 13'(r_rc);
        w_mid    = (w_msum + (w_msum[12] ? 13'sd1 : 13'sd0)) >>> 1;
        w_fd     = 14'(w_mid) - 14'(r_fspeed);
        w_isum   = 14'(r_int) + 14'(r_fspeed);
        w_target = r_curve ? 13'(CURVE_TARGET) : 13'(i_cfg.speed_target);
        w_s_adj  = r_s[38] ? r_s + 39'sd4095 : r_s;
        w_sdiv   = 27'(w_s_adj >>> 12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_yaw_sum <= '0;
            r_fspeed  <= '0;
            r_int     <= '0;
            r_scmd    <= '0;
            r_stcmd   <= '0;
            r_ss      <= '0;
            r_sstep   <= '0;
            r_st      <= '0;
            r_tstep   <= '0;
        end else begin
            unique case (i_cmd.step)
                ST_IDLE: begin
                    if (i_cmd.load) begin
                        r_tilt    <= i_item.tilt_angle;
                        r_pitch   <= i_item.pitch_rate_raw;
                        r_lc      <= i_item.left_count;
                        r_rc      <= i_item.right_count;
                        r_line    <= i_item.line_center;
                        r_curve   <= i_item.curve_flag;
                        r_phase   <= r_phase + 4'd1;
                        r_yaw_sum <= r_yaw_sum + 20'(i_item.yaw_rate_raw);
                        r_sstep   <= (r_sstep >= 2'(SPEED_STEPS)) ? 2'd1 : r_sstep + 2'd1;
                        r_tstep   <= (r_tstep >= 3'(STEER_STEPS)) ? 3'd1 : r_tstep + 3'd1;
                    end
                end
                ST_MUL_A: begin
                    r_pa    <= w_terr * i_cfg.angle_kp;
                    r_pb    <= r_pitch * i_cfg.angle_kd;
                    r_sprod <= w_sd * $signed({1'b0, r_sstep});
                    r_tprod <= w_td * $signed({1'b0, r_tstep});
                end
                ST_MUL_B: begin
                    r_pb4k <= 53'(r_pb) * 53'(GYRO_SCALE);
                    r_smag <= 38'(w_sabs[17:0]) * 38'(RECIP3);
                    r_sneg <= r_sprod[19];
                end
                ST_SUM: r_num <= (54'(r_pa) <<< 10) + 54'(r_pb4k);
                ST_PD: begin
                    r_pd <= 26'(w_num_adj >>> 28);
                    r_ss <= r_sneg ? r_ss - 16'(w_sq) : r_ss + 16'(w_sq);
                    r_st <= r_tprod[11] ? r_st - w_tq : r_st + w_tq;
                end
                ST_DRIVE: begin
                    r_res.right_forward_duty <= (w_rcl > 0) ? 10'(w_rcl) : '0;
                    r_res.right_reverse_duty <= (w_rcl < 0) ? 10'(-w_rcl) : '0;
                    r_res.left_forward_duty  <= (w_lcl > 0) ? 10'(w_lcl) : '0;
                    r_res.left_reverse_duty  <= (w_lcl < 0) ? 10'(-w_lcl) : '0;
                    r_res.motors_cut         <= w_cut;
                end
                ST_STR_MUL_A: begin
                    r_t1 <= w_lo * i_cfg.direction_kp;
                    r_t2 <= i_cfg.direction_kd * r_yaw_sum;
                end
                ST_STR_MUL_B: begin
                    r_t1s <= (58'(r_t1) * 58'(STEER_PERIOD)) <<< 15;
                    r_t2s <= 58'(r_t2) * 58'(GYRO_SCALE);
                end
                ST_STR_SUM: r_snum <= r_t1s + r_t2s;
                ST_STR_NORM: begin
                    r_qneg <= r_snum[57];
                    r_qsat <= (w_a >= 30'(DIV_LIM));
                    r_qa   <= 10'(w_a);
                end
                ST_STR_DIV: begin
                    r_stcmd   <= r_qneg ? -8'(w_q) : 8'(w_q);
                    r_yaw_sum <= '0;
                end
                ST_SPD_FILT: begin
                    if (w_fd > 14'(SPEED_RATE_LIMIT))
                        r_fspeed <= r_fspeed + 13'(SPEED_RATE_LIMIT);
                    else if (w_fd < -14'(SPEED_RATE_LIMIT))
                        r_fspeed <= r_fspeed - 13'(SPEED_RATE_LIMIT);
                    else
                        r_fspeed <= w_mid;
                end
                ST_SPD_INT: begin
                    if (w_isum > 14'(SPEED_INT_LIMIT))       r_int <= 10'(SPEED_INT_LIMIT);
                    else if (w_isum < -14'(SPEED_INT_LIMIT)) r_int <= -10'(SPEED_INT_LIMIT);
                    else                                     r_int <= 10'(w_isum);
                    r_serr <= 14'(r_fspeed) - 14'(w_target);
                end
                ST_SPD_MUL: begin
                    r_m1 <= i_cfg.speed_kp * r_serr;
                    r_m2 <= i_cfg.speed_ki * r_int;
                end
                ST_SPD_SUM: r_s <= 39'(r_m1) + 39'(r_m2);
                ST_SPD_OUT: begin
                    if (w_sdiv > 27'sd32767)       r_scmd <= 16'sh7fff;
                    else if (w_sdiv < -27'sd32768) r_scmd <= -16'sh8000;
                    else                           r_scmd <= 16'(w_sdiv);
                end
                ST_DONE: begin
                    if (r_phase >= 4'(FRAME_TICKS)) r_phase <= '0;
                    if (i_cmd.publish) r_out <= r_res;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.steer_due = STEER_MASK[r_phase];
    assign o_stat.speed_due = SPEED_MASK[r_phase];
    assign o_res            = r_out;

endmodule
